// ===== rtl/core/dmtt_pkg.sv =====
package dmtt_pkg;

  localparam int OPCODE_WIDTH = 3;
  localparam int KEY_WIDTH    = 64;
  localparam int FIT_WIDTH    = 64;
  localparam int COUNT_WIDTH  = 48;

  localparam logic [OPCODE_WIDTH-1:0] OP_FIND       = 3'd0;
  localparam logic [OPCODE_WIDTH-1:0] OP_INSERT     = 3'd1;
  localparam logic [OPCODE_WIDTH-1:0] OP_INVALIDATE = 3'd2;
  localparam logic [OPCODE_WIDTH-1:0] OP_CLEAR      = 3'd3;
  localparam logic [OPCODE_WIDTH-1:0] OP_PEEK       = 3'd4;

  localparam int IN_DATA_WIDTH  = 2 * KEY_WIDTH + FIT_WIDTH;
  localparam int OUT_USED_WIDTH = 1 + FIT_WIDTH + 2 * COUNT_WIDTH;
  localparam int OUT_DATA_WIDTH = ((OUT_USED_WIDTH + 7) / 8) * 8;
  localparam int OUT_PAD_WIDTH  = OUT_DATA_WIDTH - OUT_USED_WIDTH;

  // Decoded operation as it waits in the queue; no flag set means no operation.
  typedef struct packed {
    logic                 find;
    logic                 peek;
    logic                 insert;
    logic                 invalidate;
    logic                 clear;
    logic [KEY_WIDTH-1:0] key_first;
    logic [KEY_WIDTH-1:0] key_second;
    logic [FIT_WIDTH-1:0] fitness;
  } cmd_t;

endpackage

// ===== rtl/core/dmtt_front.sv =====
module dmtt_front (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // key_first, key_second, fitness_in
  input  logic [dmtt_pkg::IN_DATA_WIDTH-1:0]   s_axis_tdata,
  // opcode
  input  logic [dmtt_pkg::OPCODE_WIDTH-1:0]    s_axis_tuser,
  input  logic                                 clr_busy,
  output logic                                 q_valid,
  output dmtt_pkg::cmd_t                       q_cmd,
  input  logic                                 q_pop
);

  dmtt_pkg::cmd_t q_mem [2];
  dmtt_pkg::cmd_t dec;
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;
  logic           push;

  always_comb begin
    dec            = '0;
    dec.key_first  = s_axis_tdata[dmtt_pkg::KEY_WIDTH-1:0];
    dec.key_second = s_axis_tdata[2*dmtt_pkg::KEY_WIDTH-1:dmtt_pkg::KEY_WIDTH];
    dec.fitness    = s_axis_tdata[dmtt_pkg::IN_DATA_WIDTH-1:2*dmtt_pkg::KEY_WIDTH];
    case (s_axis_tuser)
      dmtt_pkg::OP_FIND:       dec.find       = 1'b1;
      dmtt_pkg::OP_INSERT:     dec.insert     = 1'b1;
      dmtt_pkg::OP_INVALIDATE: dec.invalidate = 1'b1;
      dmtt_pkg::OP_CLEAR:      dec.clear      = 1'b1;
      dmtt_pkg::OP_PEEK:       dec.peek       = 1'b1;
      default:                 dec.find       = 1'b0;
    endcase
  end

  // Hold off new transactions while the queue is full or the store is being swept after reset.
  assign s_axis_tready = (count != 2'd2) && !clr_busy;
  assign push          = s_axis_tvalid && s_axis_tready;
  assign q_valid       = (count != 2'd0);
  assign q_cmd         = q_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr] <= dec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, q_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/core/dmtt_back.sv =====
module dmtt_back #(
  parameter int INDEX_BITS    = 12,
  parameter int FITNESS_WIDTH = 64,
  parameter int SEAL_WIDTH    = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                q_valid,
  input  dmtt_pkg::cmd_t                      q_cmd,
  output logic                                q_pop,
  output logic                                clr_busy,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_hit,
  output logic [dmtt_pkg::FIT_WIDTH-1:0]      out_fit,
  output logic [dmtt_pkg::COUNT_WIDTH-1:0]    out_probe,
  output logic [dmtt_pkg::COUNT_WIDTH-1:0]    out_hits
);

  localparam int SLOTS   = 1 << INDEX_BITS;
  localparam int KEY2_W  = 2 * dmtt_pkg::KEY_WIDTH;

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_LOOK  = 2'd2;

  logic [KEY2_W-1:0]        mem_key  [SLOTS];
  logic [FITNESS_WIDTH-1:0] mem_fit  [SLOTS];
  logic [SEAL_WIDTH-1:0]    mem_seal [SLOTS];

  logic [KEY2_W-1:0]        rd_key;
  logic [FITNESS_WIDTH-1:0] rd_fit;
  logic [SEAL_WIDTH-1:0]    rd_seal;

  logic [1:0]                       state;
  logic [INDEX_BITS-1:0]            clr_addr;
  logic [SEAL_WIDTH-1:0]            cur_seal;
  logic [SEAL_WIDTH-1:0]            seal_next;
  logic [dmtt_pkg::COUNT_WIDTH-1:0] cnt_probe;
  logic [dmtt_pkg::COUNT_WIDTH-1:0] cnt_hit;
  logic [dmtt_pkg::COUNT_WIDTH-1:0] probe_next;
  logic [dmtt_pkg::COUNT_WIDTH-1:0] hit_next;
  logic                             look_find;
  logic [KEY2_W-1:0]                look_key;

  logic [INDEX_BITS-1:0]    idx;
  logic                     out_free;
  logic                     out_load;
  logic                     match;
  logic                     key_we;
  logic [INDEX_BITS-1:0]    key_wa;
  logic [KEY2_W-1:0]        key_wd;
  logic                     fit_we;
  logic                     seal_we;
  logic [SEAL_WIDTH-1:0]    seal_wd;

  assign idx      = q_cmd.key_first[INDEX_BITS-1:0];
  assign out_free = !out_valid || out_ready;
  assign q_pop    = (state == ST_IDLE) && q_valid && out_free;
  assign clr_busy = (state == ST_CLEAR);
  assign out_load = (state == ST_LOOK) || (q_pop && !(q_cmd.find || q_cmd.peek));

  // Sweep zeroes seals and keys; a slot with seal zero never matches.
  assign key_we  = clr_busy || (q_pop && (q_cmd.insert || q_cmd.invalidate));
  assign key_wa  = clr_busy ? clr_addr : idx;
  assign key_wd  = (q_pop && q_cmd.insert) ? {q_cmd.key_second, q_cmd.key_first} : '0;
  assign fit_we  = q_pop && q_cmd.insert;
  assign seal_we = clr_busy || (q_pop && q_cmd.insert);
  assign seal_wd = clr_busy ? '0 : cur_seal;

  always_ff @(posedge clk) begin
    if (key_we) begin
      mem_key[key_wa] <= key_wd;
    end
    rd_key <= mem_key[idx];
  end

  always_ff @(posedge clk) begin
    if (fit_we) begin
      mem_fit[idx] <= q_cmd.fitness[FITNESS_WIDTH-1:0];
    end
    rd_fit <= mem_fit[idx];
  end

  always_ff @(posedge clk) begin
    if (seal_we) begin
      mem_seal[key_wa] <= seal_wd;
    end
    rd_seal <= mem_seal[idx];
  end

  assign match      = (rd_seal == cur_seal) && (rd_key == look_key);
  assign probe_next = (cnt_probe == '1) ? cnt_probe : cnt_probe + 1'b1;
  assign hit_next   = (cnt_hit == '1) ? cnt_hit : cnt_hit + 1'b1;
  assign seal_next  = (cur_seal == '1) ? SEAL_WIDTH'(1) : cur_seal + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_addr  <= '0;
      cur_seal  <= SEAL_WIDTH'(1);
      cnt_probe <= '0;
      cnt_hit   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == '1) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (q_pop) begin
            if (q_cmd.find || q_cmd.peek) begin
              state     <= ST_LOOK;
              look_find <= q_cmd.find;
              look_key  <= {q_cmd.key_second, q_cmd.key_first};
            end else begin
              out_hit   <= 1'b0;
              out_fit   <= '0;
              if (q_cmd.clear) begin
                cnt_probe <= '0;
                cnt_hit   <= '0;
                cur_seal  <= seal_next;
                out_probe <= '0;
                out_hits  <= '0;
              end else begin
                out_probe <= cnt_probe;
                out_hits  <= cnt_hit;
              end
            end
          end
        end
        ST_LOOK: begin
          state     <= ST_IDLE;
          out_hit   <= match;
          out_fit   <= match ? dmtt_pkg::FIT_WIDTH'(rd_fit) : '0;
          if (look_find) begin
            cnt_probe <= probe_next;
            out_probe <= probe_next;
            if (match) begin
              cnt_hit  <= hit_next;
              out_hits <= hit_next;
            end else begin
              out_hits <= cnt_hit;
            end
          end else begin
            out_probe <= cnt_probe;
            out_hits  <= cnt_hit;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_seal_nonzero: assert property (@(posedge clk) disable iff (rst)
    cur_seal != '0)
    else $error("current seal reached zero");

  a_hits_le_probes: assert property (@(posedge clk) disable iff (rst)
    cnt_hit <= cnt_probe)
    else $error("hit count exceeds probe count");

  a_look_one_cycle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LOOK) |=> (state == ST_IDLE) && out_valid)
    else $error("lookup did not complete in one cycle");

  a_clear_result: assert property (@(posedge clk) disable iff (rst)
    (q_pop && q_cmd.clear) |=> out_valid && (out_probe == '0) && (out_hits == '0)
      && (cur_seal != $past(cur_seal)))
    else $error("clear-all result or seal advance wrong");

endmodule

// ===== rtl/core/direct_mapped_transposition_table.sv =====
// Direct-mapped cache of fitness values under a 128-bit signature, one slot per
// value of the low INDEX_BITS bits of key_first. Opcodes on s_axis_tuser: find,
// insert, invalidate slot, clear all (zero statistics, advance the seal so all
// older entries stop matching) and peek; every transaction in gives exactly one
// result out, in order. After reset the block sweeps every slot of its store
// with s_axis_tready low. Afterwards find and peek pass through the execution
// stage as a registered memory read and then the key and seal compare, while
// every other opcode finishes on acceptance; no new transaction is taken from
// the queue while a lookup is in its compare or while the result is held.
// A two-entry queue between decode and execution and a registered result let
// input and output stall independently.
module direct_mapped_transposition_table #(
  parameter int INDEX_BITS    = 12,
  parameter int FITNESS_WIDTH = 64,
  parameter int SEAL_WIDTH    = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // key_first [63:0], key_second [127:64], fitness_in [191:128]
  input  logic [dmtt_pkg::IN_DATA_WIDTH-1:0]  s_axis_tdata,
  // opcode [2:0]
  input  logic [dmtt_pkg::OPCODE_WIDTH-1:0]   s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // hit [0], fitness_out [64:1], probe_total [112:65], hit_total [160:113], zero pad
  output logic [dmtt_pkg::OUT_DATA_WIDTH-1:0] m_axis_tdata
);

  logic                             clr_busy;
  logic                             q_valid;
  logic                             q_pop;
  dmtt_pkg::cmd_t                   q_cmd;
  logic                             out_hit;
  logic [dmtt_pkg::FIT_WIDTH-1:0]   out_fit;
  logic [dmtt_pkg::COUNT_WIDTH-1:0] out_probe;
  logic [dmtt_pkg::COUNT_WIDTH-1:0] out_hits;

  dmtt_front u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .clr_busy      (clr_busy),
    .q_valid       (q_valid),
    .q_cmd         (q_cmd),
    .q_pop         (q_pop)
  );

  dmtt_back #(
    .INDEX_BITS    (INDEX_BITS),
    .FITNESS_WIDTH (FITNESS_WIDTH),
    .SEAL_WIDTH    (SEAL_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop),
    .clr_busy  (clr_busy),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_hit   (out_hit),
    .out_fit   (out_fit),
    .out_probe (out_probe),
    .out_hits  (out_hits)
  );

  assign m_axis_tdata = {{dmtt_pkg::OUT_PAD_WIDTH{1'b0}}, out_hits, out_probe, out_fit, out_hit};

endmodule

// ===== tb/tb_direct_mapped_transposition_table.sv =====
module tb_direct_mapped_transposition_table;

  localparam int INDEX_BITS     = 12;
  localparam int SLOT_COUNT     = 1 << INDEX_BITS;
  localparam int SEAL_WIDTH     = 32;
  localparam int PHASE_ITEMS    = 130;
  localparam int POOL_DEPTH     = 48;
  localparam int HOLD_CYCLES    = 400;
  localparam int DRAIN_CYCLES   = 20;
  // covers the store sweep after reset plus the long receiver hold
  localparam int WATCHDOG_LIMIT = 20000;
  localparam logic [dmtt_pkg::COUNT_WIDTH-1:0]  COUNT_MAX = '1;
  localparam logic [dmtt_pkg::OPCODE_WIDTH-1:0] OP_TOP    = '1;

  typedef struct packed {
    logic [dmtt_pkg::OPCODE_WIDTH-1:0] opcode;
    logic [dmtt_pkg::KEY_WIDTH-1:0]    key_first;
    logic [dmtt_pkg::KEY_WIDTH-1:0]    key_second;
    logic [dmtt_pkg::FIT_WIDTH-1:0]    fitness;
  } tt_op_t;

  typedef struct packed {
    logic                             hit;
    logic [dmtt_pkg::FIT_WIDTH-1:0]   fitness;
    logic [dmtt_pkg::COUNT_WIDTH-1:0] probes;
    logic [dmtt_pkg::COUNT_WIDTH-1:0] hits;
  } tt_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic                                s_axis_tvalid = 1'b0;
  logic                                s_axis_tready;
  logic [dmtt_pkg::IN_DATA_WIDTH-1:0]  s_axis_tdata  = '0;
  logic [dmtt_pkg::OPCODE_WIDTH-1:0]   s_axis_tuser  = '0;
  logic                                m_axis_tvalid;
  logic                                m_axis_tready = 1'b0;
  logic [dmtt_pkg::OUT_DATA_WIDTH-1:0] m_axis_tdata;

  direct_mapped_transposition_table DUT (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #2 clk = ~clk;

  // predicted store contents
  logic [dmtt_pkg::KEY_WIDTH-1:0]   slot_key_first  [SLOT_COUNT];
  logic [dmtt_pkg::KEY_WIDTH-1:0]   slot_key_second [SLOT_COUNT];
  logic [dmtt_pkg::FIT_WIDTH-1:0]   slot_fitness    [SLOT_COUNT];
  logic [SEAL_WIDTH-1:0]            slot_seal       [SLOT_COUNT];
  logic [SEAL_WIDTH-1:0]            current_seal = SEAL_WIDTH'(1);
  logic [dmtt_pkg::COUNT_WIDTH-1:0] probe_count  = '0;
  logic [dmtt_pkg::COUNT_WIDTH-1:0] hit_count    = '0;

  tt_op_t     pending_ops[$];
  tt_result_t expected_results[$];
  tt_op_t     in_flight;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  logic hold_go   = 1'b0;
  logic hold_seen = 1'b0;
  int   hold_left = 0;

  int mismatches     = 0;
  int results_seen   = 0;
  int matched_lookups = 0;
  int clears_sent    = 0;
  int stall_cycles   = 0;

  initial begin
    for (int i = 0; i < SLOT_COUNT; i++) begin
      slot_key_first[i]  = '0;
      slot_key_second[i] = '0;
      slot_fitness[i]    = '0;
      slot_seal[i]       = '0;
    end
  end

  // Apply one accepted transaction to the predicted store and queue its result.
  function automatic void cache_apply(tt_op_t op);
    logic [INDEX_BITS-1:0] slot;
    logic                  match;
    tt_result_t            res;
    slot  = op.key_first[INDEX_BITS-1:0];
    res   = '0;
    match = slot_seal[slot] == current_seal && slot_key_first[slot] == op.key_first &&
            slot_key_second[slot] == op.key_second;
    case (op.opcode)
      dmtt_pkg::OP_FIND, dmtt_pkg::OP_PEEK: begin
        if (match) begin
          res.hit     = 1'b1;
          res.fitness = slot_fitness[slot];
        end
        if (op.opcode == dmtt_pkg::OP_FIND) begin
          if (probe_count != COUNT_MAX) probe_count = probe_count + 1'b1;
          if (match && hit_count != COUNT_MAX) hit_count = hit_count + 1'b1;
        end
      end
      dmtt_pkg::OP_INSERT: begin
        slot_key_first[slot]  = op.key_first;
        slot_key_second[slot] = op.key_second;
        slot_fitness[slot]    = op.fitness;
        slot_seal[slot]       = current_seal;
      end
      dmtt_pkg::OP_INVALIDATE: begin
        // seal and fitness stay, so in slot 0 the all-zero key can still hit
        slot_key_first[slot]  = '0;
        slot_key_second[slot] = '0;
      end
      dmtt_pkg::OP_CLEAR: begin
        probe_count  = '0;
        hit_count    = '0;
        current_seal = current_seal + 1'b1;
        if (current_seal == '0) current_seal = SEAL_WIDTH'(1);
        clears_sent++;
      end
      default: ;
    endcase
    res.probes = probe_count;
    res.hits   = hit_count;
    expected_results.push_back(res);
  endfunction

  function automatic void queue_op(logic [dmtt_pkg::OPCODE_WIDTH-1:0] opcode,
                                   logic [dmtt_pkg::KEY_WIDTH-1:0] k1,
                                   logic [dmtt_pkg::KEY_WIDTH-1:0] k2,
                                   logic [dmtt_pkg::FIT_WIDTH-1:0] fit);
    tt_op_t op;
    op.opcode     = opcode;
    op.key_first  = k1;
    op.key_second = k2;
    op.fitness    = fit;
    pending_ops.push_back(op);
  endfunction

  // Driver: predict on each accepted transaction, then offer the next one.
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) cache_apply(in_flight);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_ops.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_flight = pending_ops.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {in_flight.fitness, in_flight.key_second, in_flight.key_first};
          s_axis_tuser  <= in_flight.opcode;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold, counted here so the sender keeps offering meanwhile.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_go != hold_seen) begin
      hold_seen <= hold_go;
      hold_left <= HOLD_CYCLES;
    end
  end

  // Monitor: compare each result with the oldest prediction.
  always @(posedge clk) begin : monitor
    tt_result_t got;
    tt_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.hit     = m_axis_tdata[0];
      got.fitness = m_axis_tdata[dmtt_pkg::FIT_WIDTH:1];
      got.probes  = m_axis_tdata[dmtt_pkg::FIT_WIDTH+dmtt_pkg::COUNT_WIDTH:
                                 dmtt_pkg::FIT_WIDTH+1];
      got.hits    = m_axis_tdata[dmtt_pkg::FIT_WIDTH+2*dmtt_pkg::COUNT_WIDTH:
                                 dmtt_pkg::FIT_WIDTH+dmtt_pkg::COUNT_WIDTH+1];
      results_seen++;
      if (got.hit) matched_lookups++;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d arrived with nothing predicted:", results_seen,
                   " hit=%0b fit=%h probes=%0d hits=%0d",
                   got.hit, got.fitness, got.probes, got.hits);
      end else begin
        want = expected_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("result %0d mismatch: expected hit=%0b fit=%h probes=%0d hits=%0d,",
                     results_seen, want.hit, want.fitness, want.probes, want.hits,
                     " got hit=%0b fit=%h probes=%0d hits=%0d",
                     got.hit, got.fitness, got.probes, got.hits);
        end
      end
    end
    m_axis_tready <= !rst && hold_left == 0 && $urandom_range(99) >= recv_stall_pct;
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles, %0d results outstanding",
                 stall_cycles, expected_results.size());
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    int send_pct [5] = '{0, 47, 0, 25, 0};
    int recv_pct [5] = '{0, 0, 47, 25, 0};
    logic [2*dmtt_pkg::KEY_WIDTH-1:0] key_pool[$];
    logic [2*dmtt_pkg::KEY_WIDTH-1:0] pick;
    logic [dmtt_pkg::KEY_WIDTH-1:0]   fresh_first;
    logic [dmtt_pkg::KEY_WIDTH-1:0]   fresh_second;
    tt_op_t item;
    int roll;
    int sub;
    int total_items;

    repeat (9) @(negedge clk);
    rst = 1'b0;

    // fresh store, exact match, peek, collisions, invalidated slot, unknown opcodes, clear
    queue_op(dmtt_pkg::OP_FIND,       '0, '0, '0);
    queue_op(dmtt_pkg::OP_PEEK,       '1, '1, '1);
    queue_op(dmtt_pkg::OP_INSERT,     64'hFFFF_FFFF_FFFF_F000, '1, '1);
    queue_op(dmtt_pkg::OP_FIND,       64'hFFFF_FFFF_FFFF_F000, '1, '0);
    queue_op(dmtt_pkg::OP_PEEK,       64'hFFFF_FFFF_FFFF_F000, '1, '0);
    queue_op(dmtt_pkg::OP_INSERT,     64'h0000_0000_0000_0FFF, '0, '0);
    queue_op(dmtt_pkg::OP_FIND,       64'h0000_0000_0000_0FFF, '0, '1);
    queue_op(dmtt_pkg::OP_FIND,       64'h0000_0000_0000_0FFF, 64'h1, '0);
    queue_op(dmtt_pkg::OP_INVALIDATE, 64'h1234_5678_0000_0000, '1, '1);
    queue_op(dmtt_pkg::OP_FIND,       64'hFFFF_FFFF_FFFF_F000, '1, '0);
    queue_op(dmtt_pkg::OP_FIND,       '0, '0, '0);
    queue_op(dmtt_pkg::OP_PEEK,       '0, '0, '0);
    queue_op(dmtt_pkg::OPCODE_WIDTH'(dmtt_pkg::OP_PEEK + 1), '1, '1, '1);
    queue_op(dmtt_pkg::OPCODE_WIDTH'(dmtt_pkg::OP_PEEK + 2),
             64'hA5A5_A5A5_A5A5_A5A5, 64'h5A5A_5A5A_5A5A_5A5A, '1);
    queue_op(OP_TOP,                  '0, '1, '0);
    queue_op(dmtt_pkg::OP_CLEAR,      '1, '1, '1);
    queue_op(dmtt_pkg::OP_FIND,       64'h0000_0000_0000_0FFF, '0, '0);
    queue_op(dmtt_pkg::OP_FIND,       '0, '0, '0);
    queue_op(dmtt_pkg::OP_INSERT,     64'hFFFF_FFFF_FFFF_F000, '1, 64'h5);
    queue_op(dmtt_pkg::OP_FIND,       64'hFFFF_FFFF_FFFF_F000, '1, '0);
    queue_op(dmtt_pkg::OP_INSERT,     64'h8000_0000_0000_0000, 64'hC3C3_0000_FFFF_3C3C,
             64'h8000_0000_0000_0001);
    queue_op(dmtt_pkg::OP_FIND,       64'hFFFF_FFFF_FFFF_F000, '1, '0);
    queue_op(dmtt_pkg::OP_FIND,       64'h8000_0000_0000_0000, 64'hC3C3_0000_FFFF_3C3C, '0);
    total_items = pending_ops.size();

    for (int phase = 0; phase < 5; phase++) begin
      send_idle_pct  = send_pct[phase];
      recv_stall_pct = recv_pct[phase];
      if (phase == 4) hold_go = ~hold_go;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        roll = $urandom_range(99);
        sub  = $urandom_range(19);
        pick = (key_pool.size() != 0) ? key_pool[$urandom_range(key_pool.size() - 1)] : '0;
        fresh_first  = {$urandom, $urandom};
        fresh_second = {$urandom, $urandom};
        // crowd half the fresh keys into a few slots to force collisions
        if ($urandom_range(1) != 0) fresh_first[INDEX_BITS-1:0] = INDEX_BITS'($urandom_range(7));
        item.fitness = {$urandom, $urandom};
        {item.key_second, item.key_first} = pick;
        if (roll < 30) begin
          item.opcode = dmtt_pkg::OP_INSERT;
          if (key_pool.size() == 0 || sub < 14) begin
            item.key_first  = fresh_first;
            item.key_second = fresh_second;
            key_pool.push_back({fresh_second, fresh_first});
            if (key_pool.size() > POOL_DEPTH) void'(key_pool.pop_front());
          end
        end else if (roll < 70) begin
          item.opcode = (roll < 60) ? dmtt_pkg::OP_FIND : dmtt_pkg::OP_PEEK;
          if (sub >= 17) begin
            item.key_first  = fresh_first;
            item.key_second = fresh_second;
          end else if (sub == 16) begin
            item.key_first  = '0;
            item.key_second = '0;
          end else if (sub >= 14) begin
            item.key_second[$urandom_range(dmtt_pkg::KEY_WIDTH - 1)] ^= 1'b1;
          end
        end else if (roll < 80) begin
          item.opcode = dmtt_pkg::OP_INVALIDATE;
          if (sub >= 16) item.key_first = fresh_first;
        end else if (roll < 84) begin
          item.opcode = dmtt_pkg::OP_CLEAR;
        end else if (roll < 90) begin
          item.opcode = dmtt_pkg::OPCODE_WIDTH'($urandom_range(dmtt_pkg::OP_PEEK + 1, OP_TOP));
        end else begin
          item.opcode = dmtt_pkg::OP_FIND;
        end
        pending_ops.push_back(item);
      end
      total_items += PHASE_ITEMS;
      while (pending_ops.size() != 0) @(negedge clk);
    end

    while (s_axis_tvalid) @(negedge clk);
    while (expected_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Sent %0d operations (%0d clears) over idle, stall and long-hold phases;",
             total_items, clears_sent);
    $display("checked %0d results, %0d lookups matched, %0d mismatches.",
             results_seen, matched_lookups, mismatches);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
